@@ rtl/core/mf3_pkg.sv @@
// ----------------------------------------------------------------------------
// mf3_pkg
// shared constants and types of the 3x3 median filter core
// ----------------------------------------------------------------------------
package mf3_pkg;

  // frame geometry
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE   = 3;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);      // column counter / line store address
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);  // holds the width itself
  localparam int unsigned ROW_W = 12;

  // field widths
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned OUT_ROW_W  = 12;
  localparam int unsigned OUT_COL_W  = 10;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 32;

  // register reset values
  localparam int unsigned FW_RESET = 640;
  localparam int unsigned FH_RESET = 480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // result queue
  localparam int unsigned FIFO_DEPTH   = 8;
  localparam int unsigned FQ_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FQ_CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned RES_PER_ITEM = 3;
  localparam int unsigned RES_IDX_W    = 2;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic                 frame_done;
    logic                 is_median;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    pix_t                 pixel_out;
  } result_t;

  // up to three results caused by one pixel, packed from slot 0
  typedef struct packed {
    logic [RES_IDX_W-1:0]         n;
    result_t [RES_PER_ITEM-1:0]   res;
  } bundle_t;

  // per-pixel control and data carried down the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             e0;    // window result for (row-1, col-1)
    logic             m0;    // that result is a median
    logic             e1;    // right border copy of the row above
    logic             e2;    // last row copy
    logic             done;  // last pixel of the frame
    pix_t             v0;    // border copy value for the window result
    pix_t             mid;   // pixel of the row above
    pix_t             px;    // incoming pixel
  } item_t;

endpackage

@@ rtl/core/mf3_ram.sv @@
// ----------------------------------------------------------------------------
// mf3_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mf3_median.sv @@
// ----------------------------------------------------------------------------
// mf3_median
// nine-input median network, two register stages, result combinational
// behind the second stage
// ----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
  input  logic           clk_i,
  input  pix_t [8:0]     win_i,
  output pix_t           med_o
);

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  pix_t [2:0] mn_q, md_q, mx_q;
  pix_t       lo_q, mid_q, hi_q;

  // sort each triplet
  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 3; t++) begin
      mn_q[t] <= min2(min2(win_i[3*t], win_i[3*t+1]), win_i[3*t+2]);
      md_q[t] <= med3(win_i[3*t], win_i[3*t+1], win_i[3*t+2]);
      mx_q[t] <= max2(max2(win_i[3*t], win_i[3*t+1]), win_i[3*t+2]);
    end
  end

  // max of mins, median of mids, min of maxes
  always_ff @(posedge clk_i) begin
    lo_q  <= max2(max2(mn_q[0], mn_q[1]), mn_q[2]);
    mid_q <= med3(md_q[0], md_q[1], md_q[2]);
    hi_q  <= min2(min2(mx_q[0], mx_q[1]), mx_q[2]);
  end

  assign med_o = med3(lo_q, mid_q, hi_q);

endmodule

@@ rtl/core/median_filter_3x3_core.sv @@
// ----------------------------------------------------------------------------
// median_filter_3x3_core
// 3x3 median filter over a raster stream of 8-bit grey pixels
// ----------------------------------------------------------------------------
// path: an input transfer passes the stage registers, the result queue and the output
//   register before its first result shows on the master side
// throughput: one pixel per cycle while s_tready is high; the master side moves one
//   result per cycle while m_tready allows, so a last-column pixel (two results) or a
//   last-row pixel (up to three) waits in an 8-entry result queue; a full credit holds the input
// reset: counters and window cleared, width 640, height 480; line store
//   contents stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module median_filter_3x3_core import mf3_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] pixel_in
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,   // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
  output logic                   m_tuser,   // is_median
  output logic                   m_tlast    // frame_done
);

  localparam int unsigned SUM_W = FQ_CNT_W + 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(FW_RESET);
      frame_height_q <= FH_W'(FH_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  logic [CNT_W-1:0] w_eff;
  logic [FH_W-1:0]  h_eff;

  always_comb begin
    if (frame_width_q < FW_W'(MIN_SIZE)) begin
      w_eff = CNT_W'(MIN_SIZE);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(frame_width_q);
    end
    if (frame_height_q < FH_W'(MIN_SIZE)) begin
      h_eff = FH_W'(MIN_SIZE);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: raster position, line store read
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s_accept;

  logic             col_wrap;
  logic [FH_W-1:0]  row_pre;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             last_col, last_row;
  logic [CNT_W-1:0] col_nxt;
  logic [FH_W-1:0]  row_inc;
  item_t            s0_item;

  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    // a counter left beyond a shrunk frame wraps before use
    col_wrap = CNT_W'(col_q) >= w_eff;
    row_pre  = col_wrap ? (FH_W'(row_q) + FH_W'(1)) : FH_W'(row_q);
    cur_row  = (row_pre >= h_eff) ? '0 : row_pre[ROW_W-1:0];
    cur_col  = col_wrap ? '0 : col_q;
    last_col = CNT_W'(cur_col) == (w_eff - CNT_W'(1));
    last_row = FH_W'(cur_row) == (h_eff - FH_W'(1));

    // advance the raster position
    col_nxt = CNT_W'(cur_col) + CNT_W'(1);
    row_inc = FH_W'(cur_row) + FH_W'(1);
    if (col_nxt >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_nxt[COL_W-1:0];
      row_d = cur_row;
    end

    s0_item      = '0;
    s0_item.row  = cur_row;
    s0_item.col  = cur_col;
    s0_item.e0   = (cur_row != '0) && (cur_col != '0);
    s0_item.m0   = (cur_row > ROW_W'(1)) && (cur_col > COL_W'(1));
    s0_item.e1   = (cur_row != '0) && last_col;
    s0_item.e2   = last_row;
    s0_item.done = last_row && last_col;
    s0_item.px   = s_tdata[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line store data arrives, window update, line store write back
  // --------------------------------------------------------------------------
  logic        s1_v_q, s2_v_q, s3_v_q;
  item_t       s1_q, s2_q, s3_q;
  item_t       s1_full;
  logic [2*PIX_W-1:0] ram_rdata;
  pix_t        top_px, mid_px;
  pix_t        wc_q [6];
  pix_t [8:0]  win;
  pix_t        med;

  // one entry per column: upper byte two rows above, lower byte the row above
  mf3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_q.col),
    .wdata_i ({mid_px, s1_q.px}),
    .re_i    (s_accept),
    .raddr_i (cur_col),
    .rdata_o (ram_rdata)
  );

  assign top_px = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid_px = ram_rdata[PIX_W-1:0];

  // window columns: entries 0..2 two columns back, 3..5 one column back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        wc_q[k] <= '0;
      end
    end else if (s1_v_q) begin
      wc_q[0] <= wc_q[3];
      wc_q[1] <= wc_q[4];
      wc_q[2] <= wc_q[5];
      wc_q[3] <= top_px;
      wc_q[4] <= mid_px;
      wc_q[5] <= s1_q.px;
    end
  end

  always_comb begin
    win[0] = wc_q[0];
    win[1] = wc_q[3];
    win[2] = top_px;
    win[3] = wc_q[1];
    win[4] = wc_q[4];
    win[5] = mid_px;
    win[6] = wc_q[2];
    win[7] = wc_q[5];
    win[8] = s1_q.px;
  end

  // median available in stage 3
  mf3_median u_median (
    .clk_i (clk_i),
    .win_i (win),
    .med_o (med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s_accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // border copy value and the pixel of the row above join the item here
  always_comb begin
    s1_full     = s1_q;
    s1_full.v0  = wc_q[4];
    s1_full.mid = mid_px;
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s0_item;
    s2_q <= s1_full;
    s3_q <= s2_q;
  end

  // --------------------------------------------------------------------------
  // stage 3: build the results of one pixel and queue them as a bundle
  // --------------------------------------------------------------------------
  result_t r0, r1, r2;
  bundle_t push_b;
  logic    push;

  always_comb begin
    r0.pixel_out  = s3_q.m0 ? med : s3_q.v0;
    r0.out_row    = OUT_ROW_W'(s3_q.row - ROW_W'(1));
    r0.out_col    = OUT_COL_W'(s3_q.col - COL_W'(1));
    r0.is_median  = s3_q.m0;
    r0.frame_done = 1'b0;

    r1.pixel_out  = s3_q.mid;
    r1.out_row    = OUT_ROW_W'(s3_q.row - ROW_W'(1));
    r1.out_col    = OUT_COL_W'(s3_q.col);
    r1.is_median  = 1'b0;
    r1.frame_done = 1'b0;

    r2.pixel_out  = s3_q.px;
    r2.out_row    = OUT_ROW_W'(s3_q.row);
    r2.out_col    = OUT_COL_W'(s3_q.col);
    r2.is_median  = 1'b0;
    r2.frame_done = s3_q.done;

    // pack the present results from slot 0 up
    push_b = '0;
    if (s3_q.e0) begin
      push_b.res[push_b.n] = r0;
      push_b.n             = push_b.n + RES_IDX_W'(1);
    end
    if (s3_q.e1) begin
      push_b.res[push_b.n] = r1;
      push_b.n             = push_b.n + RES_IDX_W'(1);
    end
    if (s3_q.e2) begin
      push_b.res[push_b.n] = r2;
      push_b.n             = push_b.n + RES_IDX_W'(1);
    end
    push = s3_v_q && (push_b.n != '0);
  end

  // --------------------------------------------------------------------------
  // result queue and output register
  // --------------------------------------------------------------------------
  bundle_t               fifo_q [FIFO_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FQ_CNT_W-1:0]   cnt_q;
  logic [RES_IDX_W-1:0]  sub_q;
  bundle_t               head;
  logic                  out_load, have, head_last, pop;
  logic                  m_tvalid_q;
  result_t               out_q;
  logic [SUM_W-1:0]      credit_used;

  assign head      = fifo_q[rd_ptr_q];
  assign have      = cnt_q != '0;
  assign out_load  = !m_tvalid_q || m_tready;
  assign head_last = sub_q == (head.n - RES_IDX_W'(1));
  assign pop       = out_load && have && head_last;

  // every pixel in flight holds a queue slot until its bundle, if any, leaves
  assign credit_used = SUM_W'(cnt_q) + SUM_W'(s1_v_q) + SUM_W'(s2_v_q) + SUM_W'(s3_v_q);
  assign s_tready    = credit_used < SUM_W'(FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= push_b;
    end
    if (out_load && have) begin
      out_q <= head.res[sub_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      sub_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FQ_PTR_W'(1);
      end
      cnt_q <= cnt_q + FQ_CNT_W'(push) - FQ_CNT_W'(pop);
      if (out_load) begin
        m_tvalid_q <= have;
        if (have) begin
          sub_q <= head_last ? '0 : (sub_q + RES_IDX_W'(1));
        end
      end
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = TDATA_OUT_W'({out_q.out_col, out_q.out_row, out_q.pixel_out});
  assign m_tuser  = out_q.is_median;
  assign m_tlast  = out_q.frame_done;

`ifndef SYNTH
  // a line store entry is never read in the cycle it is written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s_accept) |-> (s1_q.col != cur_col))
    else $error("line store read and write hit the same column");

  // the credit check keeps room for every pixel in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= SUM_W'(FIFO_DEPTH))
    else $error("result queue credit exceeded");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (cnt_q < FQ_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  // the slot index stays inside the head bundle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    have |-> (sub_q < head.n))
    else $error("result slot index beyond head bundle");
`endif

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// regression bench for the 3x3 median filter core: pixels go in on the
// slave stream, a local model of the filter works out the value, position,
// median flag and frame end of every result, and each result transfer on the
// master stream is checked against the oldest prediction; frame sizes are
// reprogrammed between phases, including the clamped and mid-frame cases
// ----------------------------------------------------------------------------
module tb_top;
  import mf3_pkg::*;

  // cycles the core may still be busy on a pixel that produces no result
  localparam int unsigned SETTLE_CYCLES  = 16;
  // cycles with no transfer of any kind before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // random part of the stimulus, in pixels
  localparam int unsigned RANDOM_ITEMS   = 180;
  // pixels sent into the first row of a frame at the clamped maximum size
  localparam int unsigned WIDE_ROW_ITEMS = 24;

  typedef enum int unsigned {
    PAT_RANDOM,    // uniform 0..255
    PAT_EXTREMES,  // only 0 and 255
    PAT_SPLIT,     // mix of upper and lower half, stresses unsigned ordering
    PAT_RAMP       // steady gradient
  } pix_pattern_e;

  typedef enum int unsigned {
    RX_STREAM,     // always ready
    RX_SPARSE,     // ready three times out of four on average
    RX_STALLS      // runs of stalls of random length
  } rx_mode_e;

  // --------------------------------------------------------------------------
  // clock, reset and core ports
  // --------------------------------------------------------------------------
  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_tvalid   = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata    = '0;   // [7:0] pixel_in
  logic                   m_tvalid;
  logic                   m_tready   = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;           // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
  logic                   m_tuser;           // is_median
  logic                   m_tlast;           // frame_done

  always #10 clk_i = ~clk_i;

  median_filter_3x3_core dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_tvalid,
    .s_tready,
    .s_tdata,
    .m_tvalid,
    .m_tready,
    .m_tdata,
    .m_tuser,
    .m_tlast
  );

  // --------------------------------------------------------------------------
  // filter model: registers, line buffers, window and raster position
  // --------------------------------------------------------------------------
  logic [FW_W-1:0] width_reg  = FW_W'(FW_RESET);
  logic [FH_W-1:0] height_reg = FH_W'(FH_RESET);
  pix_t            row_above  [MAX_WIDTH];   // row r-1
  pix_t            row_above2 [MAX_WIDTH];   // row r-2
  pix_t            win_col    [6];           // two older columns, top/mid/bottom each
  int unsigned     row_idx = 0;
  int unsigned     col_idx = 0;

  result_t         awaited_results [$];
  int unsigned     mismatch_count = 0;
  int unsigned     quiet_cycles   = 0;
  int unsigned     burst_left     = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_col[i] = '0;
  end

  // sizes outside the legal range are clamped, not rejected
  function automatic int unsigned eff_width();
    if (width_reg < FW_W'(MIN_SIZE)) return MIN_SIZE;
    if (width_reg > FW_W'(MAX_WIDTH)) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < FH_W'(MIN_SIZE)) return MIN_SIZE;
    if (height_reg > FH_W'(MAX_HEIGHT)) return MAX_HEIGHT;
    return int'(height_reg);
  endfunction

  // fifth smallest of nine, plain unsigned compare
  function automatic pix_t median_of_nine(input logic [8:0][PIX_W-1:0] v);
    pix_t s [9];
    pix_t t;
    int   j;
    for (int i = 0; i < 9; i++) s[i] = v[i];
    for (int i = 1; i < 9; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[4];
  endfunction

  function automatic void queue_result(input pix_t pix, input int unsigned r,
                                       input int unsigned c, input logic med,
                                       input logic done);
    result_t res;
    res.pixel_out  = pix;
    res.out_row    = r[OUT_ROW_W-1:0];
    res.out_col    = c[OUT_COL_W-1:0];
    res.is_median  = med;
    res.frame_done = done;
    awaited_results.push_back(res);
  endfunction

  // one accepted pixel: wrap the raster position, emit what it completes,
  // then shift the line buffers and the window
  function automatic void filter_step(input pix_t px);
    int unsigned           w;
    int unsigned           h;
    int unsigned           r;
    int unsigned           c;
    pix_t                  top;
    pix_t                  mid;
    logic [8:0][PIX_W-1:0] nbhd;
    w = eff_width();
    h = eff_height();
    // a size shrunk under the current position wraps at the next pixel
    if (col_idx >= w) begin
      col_idx = 0;
      row_idx++;
    end
    if (row_idx >= h) row_idx = 0;
    r   = row_idx;
    c   = col_idx;
    top = row_above2[c];
    mid = row_above[c];

    if (r >= 1) begin
      // the pixel one up and one left is now complete
      if (c >= 1) begin
        if (r >= 2 && c >= 2) begin
          nbhd = {win_col[0], win_col[3], top,
                  win_col[1], win_col[4], mid,
                  win_col[2], win_col[5], px};
          queue_result(median_of_nine(nbhd), r - 1, c - 1, 1'b1, 1'b0);
        end else begin
          queue_result(win_col[4], r - 1, c - 1, 1'b0, 1'b0);
        end
      end
      // right border of the row above
      if (c == w - 1) queue_result(mid, r - 1, c, 1'b0, 1'b0);
    end
    // bottom row goes straight through, the last one closes the frame
    if (r == h - 1) queue_result(px, r, c, 1'b0, (c == w - 1));

    row_above2[c] = mid;
    row_above[c]  = px;
    win_col[0]    = win_col[3];
    win_col[1]    = win_col[4];
    win_col[2]    = win_col[5];
    win_col[3]    = top;
    win_col[4]    = mid;
    win_col[5]    = px;

    col_idx++;
    if (col_idx >= w) begin
      col_idx = 0;
      row_idx++;
      if (row_idx >= h) row_idx = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // monitor: result check first, then register writes and pixel transfers
  // feed the model, so everything seen at one edge is handled in one place
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        seen.pixel_out  = m_tdata[7:0];
        seen.out_row    = m_tdata[19:8];
        seen.out_col    = m_tdata[29:20];
        seen.is_median  = m_tuser;
        seen.frame_done = m_tlast;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display({"%0t: unexpected result, expected none, actual pix=%0d row=%0d",
                    " col=%0d med=%0b last=%0b"},
                   $time, seen.pixel_out, seen.out_row, seen.out_col,
                   seen.is_median, seen.frame_done);
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            $display({"%0t: result mismatch, expected pix=%0d row=%0d col=%0d",
                      " med=%0b last=%0b, actual pix=%0d row=%0d col=%0d",
                      " med=%0b last=%0b"},
                     $time, want.pixel_out, want.out_row, want.out_col,
                     want.is_median, want.frame_done, seen.pixel_out,
                     seen.out_row, seen.out_col, seen.is_median,
                     seen.frame_done);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  width_reg  = cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) filter_step(s_tdata);

      // watchdog: any transfer or write counts as progress
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("median_filter_3x3_core regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: switches between free flow, sparse ready and long stalls
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode     = RX_STREAM;
  int unsigned rx_phase    = 0;
  int unsigned rx_stall    = 0;

  always @(negedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 2));
      rx_phase = $urandom_range(20, 150);
    end
    rx_phase--;
    case (rx_mode)
      RX_STREAM: m_tready <= 1'b1;
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
          rx_stall = $urandom_range(1, 9);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // bursts of random length, random gaps in between; valid stays up across
  // back-to-back pixels
  task automatic send_pixel(input pix_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
  endtask

  function automatic pix_t make_pixel(input pix_pattern_e pat, input int unsigned n);
    case (pat)
      PAT_EXTREMES: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_SPLIT:    return ($urandom_range(0, 1) != 0) ? pix_t'($urandom_range(128, 255))
                                                       : pix_t'($urandom_range(0, 127));
      PAT_RAMP:     return pix_t'(n * 7);
      default:      return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixels(input int unsigned count, input pix_pattern_e pat);
    for (int unsigned i = 0; i < count; i++) send_pixel(make_pixel(pat, i));
  endtask

  // stop sending and wait for every predicted result, plus the tail of
  // pixels that produce nothing
  task automatic settle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic configure_frame(input int unsigned width_raw, input int unsigned height_raw);
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(width_raw));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(height_raw));
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // zero sizes clamp to 3x3; extreme values and values on both sides of 128
  // so a signed compare would pick the wrong median
  task automatic test_unsigned_borders();
    pix_t first_frame  [9];
    pix_t second_frame [12];
    first_frame  = '{8'd255, 8'd0, 8'd128, 8'd127, 8'd1, 8'd254, 8'd200, 8'd3, 8'd130};
    second_frame = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0,
                     8'd128, 8'd129, 8'd127, 8'd126};
    configure_frame(0, 0);
    foreach (first_frame[i]) send_pixel(first_frame[i]);
    configure_frame(4, 3);
    foreach (second_frame[i]) send_pixel(second_frame[i]);
  endtask

  // width shrunk below the current column, then height shrunk below the
  // current row, both in the middle of a frame
  task automatic test_resize_mid_frame();
    configure_frame(8, 6);
    send_pixels(22, PAT_SPLIT);          // stops at row 2, column 6
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
    send_pixels(5, PAT_RANDOM);          // wraps into row 3
    settle();
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(3));
    send_pixels(15, PAT_EXTREMES);       // row 4 wraps to a new frame
  endtask

  // top register values clamp to the widest and tallest frame, so the first
  // row stays open and nothing may come out
  task automatic test_clamped_maximum();
    configure_frame((1 << FW_W) - 1, (1 << FH_W) - 1);
    send_pixels(WIDE_ROW_ITEMS, PAT_RANDOM);
  endtask

  // mostly whole frames of small random size, some cut short, some with a
  // pause until the output side has caught up
  task automatic test_random_frames();
    int unsigned  sent;
    int unsigned  total;
    int unsigned  cut;
    int unsigned  pause_at;
    int unsigned  width_raw;
    int unsigned  height_raw;
    int unsigned  width_eff;
    pix_pattern_e pat;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       width_raw = $urandom_range(0, 2);
        1:       width_raw = $urandom_range(11, 40);
        default: width_raw = $urandom_range(3, 10);
      endcase
      case ($urandom_range(0, 5))
        0:       height_raw = $urandom_range(0, 2);
        1:       height_raw = $urandom_range(7, 12);
        default: height_raw = $urandom_range(3, 6);
      endcase
      // past row 0 an unfinished frame may keep or narrow its width only,
      // wider rows would read line buffer entries never written
      width_eff = (width_raw < MIN_SIZE) ? MIN_SIZE : width_raw;
      if (row_idx != 0 && width_eff > eff_width()) width_raw = eff_width();
      configure_frame(width_raw, height_raw);

      total    = eff_width() * eff_height();
      cut      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, total - 1) : total;
      if (cut > RANDOM_ITEMS - sent) cut = RANDOM_ITEMS - sent;
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, cut) : cut + 1;
      pat      = pix_pattern_e'($urandom_range(0, 3));
      for (int unsigned i = 0; i < cut; i++) begin
        if (i == pause_at) settle();
        send_pixel(make_pixel(pat, i));
      end
      sent += cut;
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unsigned_borders();
    test_resize_mid_frame();
    test_clamped_maximum();
    test_random_frames();

    // all predicted results in and the core quiet again
    settle();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("median_filter_3x3_core regression: pass");
    end else begin
      $display("median_filter_3x3_core regression: fail");
    end
    $finish;
  end

endmodule
